// File: rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg - shared definitions for the triangular smoothing filter
// Field widths, register reset value, sequencer states and the status
// bundle of the serial divider.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int HALF_W       = 5;
  localparam int SEEN_W       = 6;
  localparam int MAX_HALF_DEF = 16;

  localparam logic [HALF_W-1:0]   HALF_RESET = 5'd1;
  localparam logic [SEEN_W-1:0]   SEEN_MAX   = 6'd63;
  localparam logic [SAMPLE_W-1:0] SAT_POS    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG    = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } tsf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/tsf_if.sv
// ----------------------------------------------------------------------------
// tsf_if - channel interfaces of the triangular smoothing filter
// Sample input, smoothed output and half-width register write channel.
// ----------------------------------------------------------------------------
interface tsf_in_if import tsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface tsf_out_if import tsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic                       last_res;

  modport source (output valid, smoothed, last_res, input ready);
  modport sink   (input valid, smoothed, last_res, output ready);
endinterface

interface tsf_cfg_if import tsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tsf_window_mem.sv
// ----------------------------------------------------------------------------
// tsf_window_mem - sample history memory
// Circular buffer of samples, one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tsf_window_mem import tsf_pkg::*; #(
  parameter int AW = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tsf_divider.sv
// ----------------------------------------------------------------------------
// tsf_divider - serial restoring divider
// Unsigned num / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsf_divider import tsf_pkg::*; #(
  parameter int NW = 27,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output div_stat_t     stat
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nq, nq_next;
  logic [DW-1:0] rem, rem_next;
  logic [DW-1:0] dd;
  logic [CW-1:0] cnt;
  logic          busy, done;
  logic [DW:0]   trial;
  logic          ge;

  // shift one dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial    = {rem, nq[NW-1]};
    ge       = (trial >= {1'b0, dd});
    rem_next = ge ? DW'(trial - {1'b0, dd}) : DW'(trial);
    nq_next  = {nq[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
      dd  <= den;
    end else if (busy) begin
      nq  <= nq_next;
      rem <= rem_next;
    end
  end

  assign quo       = nq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/triangular_smoothing_filter_unit.sv
// ----------------------------------------------------------------------------
// triangular_smoothing_filter_unit - tent-kernel smoothing of a sample stream
// Each output is the tent-weighted mean of the taps present in the stream,
// rounded to nearest with ties away from zero; outputs lag by half_width.
//
//   channel  dir  payload               transfer when
//   din      in   sample[15:0], last    din.valid  & din.ready
//   dout     out  smoothed[15:0], last_res  dout.valid & dout.ready
//   cfg      in   data[4:0] half_width  cfg.valid  & cfg.ready (always ready)
//
// Sequence: an item is accepted in idle; each output then runs a tap pass
//   (at most 2h+1 taps read, then a closing tap state), starts the divide,
//   waits on it and loads the result into the output register.
//   NW = 2 + 16 + clog2((MAX_HALF+1)^2 + 1) (27 at MAX_HALF = 16); the tap
//   pass is bound by the single read port of the window memory and the
//   divide by the one-bit-per-cycle divider. A last item flushes up to h+1
//   outputs back to back through the same path.
// Reset: synchronous; half_width returns to 1, stream count to zero. The
//   window memory is not cleared; only written entries are ever read.
// Stalls: din.ready is high only in idle. A result waits in the output
//   register; the next item is taken while it is still pending.
// ----------------------------------------------------------------------------
module triangular_smoothing_filter_unit import tsf_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic  clk,
  input  logic  rst,
  tsf_in_if.sink   din,
  tsf_out_if.source dout,
  tsf_cfg_if.sink  cfg
);

  localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
  localparam int AW        = $clog2(WIN_DEPTH);             // age / address width
  localparam int HW        = $clog2(MAX_HALF + 1);          // effective half width
  localparam int WW        = $clog2(MAX_HALF + 2);          // tap weight
  localparam int DENW      = $clog2((MAX_HALF + 1) * (MAX_HALF + 1) + 1);
  localparam int MAGW      = SAMPLE_W + DENW;
  localparam int ACCW      = MAGW + 1;
  localparam int PW        = SAMPLE_W + WW + 1;
  localparam int NW        = MAGW + 2;
  localparam int DW        = DENW + 1;

  // configuration and stream state
  logic [HALF_W-1:0] half_width;
  logic [SEEN_W-1:0] seen, seen_next;
  logic [AW-1:0]     wr_ptr;

  // sequencer
  tsf_state_t        state, state_next;
  logic [HW-1:0]     hcur, hcur_next;
  logic [AW-1:0]     ctr, ctr_next;
  logic [AW-1:0]     j, j_next;
  logic              lastf, lastf_next;
  logic              init;

  // tap accumulation
  logic                   pv, pv_next;
  logic [WW-1:0]          pw, pw_next;
  logic signed [ACCW-1:0] acc, acc_next;
  logic [DENW-1:0]        den, den_next;

  // output register
  logic                       ovalid, ovalid_next;
  logic signed [SAMPLE_W-1:0] osm, osm_next;
  logic                       olast, olast_next;

  // memory and divider
  logic                       mem_we;
  logic [AW-1:0]              raddr;
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       div_start;
  logic [NW-1:0]              div_num;
  logic [DW-1:0]              div_den;
  logic [NW-1:0]              quo;
  div_stat_t                  div_stat;

  // helpers
  logic                   accept;
  logic [HW-1:0]          h_eff;
  logic [SEEN_W-1:0]      seen_inc;
  logic [AW-1:0]          hi;
  logic [AW-1:0]          tap_dist;
  logic                   issue;
  logic signed [PW-1:0]   prod;
  logic                   neg;
  logic [MAGW-1:0]        mag;
  logic [SAMPLE_W-1:0]    res;

  tsf_window_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (din.sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsf_divider #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  assign cfg.ready  = 1'b1;
  assign din.ready  = (state == ST_IDLE);
  assign accept     = din.valid && din.ready;
  assign mem_we     = accept;
  assign dout.valid    = ovalid;
  assign dout.smoothed = osm;
  assign dout.last_res = olast;

  // saturate the register to the deepest kernel the window holds
  assign h_eff    = (half_width > HALF_W'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(half_width);
  assign seen_inc = (seen == SEEN_MAX) ? SEEN_MAX : seen + 1'b1;

  // tap window of the current center: ages max(ctr-h,0) .. ctr+h
  assign hi       = ctr + AW'(hcur);
  assign tap_dist = (j >= ctr) ? j - ctr : ctr - j;
  assign issue    = (j <= hi) && (SEEN_W'(j) < seen);
  assign raddr    = wr_ptr - AW'(1) - j;

  assign prod  = rdata * $signed({1'b0, pw});

  // round to nearest: (2|acc| + den) / (2 den), sign applied afterward
  assign neg     = acc[ACCW-1];
  assign mag     = neg ? MAGW'(-acc) : MAGW'(acc);
  assign div_num = NW'({mag, 1'b0}) + NW'(den);
  assign div_den = {den, 1'b0};

  always_comb begin
    if (neg) begin
      res = (quo >= NW'(32768)) ? SAT_NEG : SAMPLE_W'(~quo[SAMPLE_W-1:0] + 1'b1);
    end else begin
      res = (quo >= NW'(32767)) ? SAT_POS : quo[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    hcur_next   = hcur;
    ctr_next    = ctr;
    j_next      = j;
    lastf_next  = lastf;
    seen_next   = seen;
    init        = 1'b0;
    pv_next     = 1'b0;
    pw_next     = pw;
    acc_next    = acc;
    den_next    = den;
    div_start   = 1'b0;
    ovalid_next = ovalid && !dout.ready;
    osm_next    = osm;
    olast_next  = olast;

    // fold the tap read last cycle into the running sums
    if (pv) begin
      acc_next = acc + ACCW'(prod);
      den_next = den + DENW'(pw);
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          seen_next  = seen_inc;
          hcur_next  = h_eff;
          lastf_next = din.last;
          if (din.last) begin
            // flush: centers h down to 0, clipped to the samples present
            ctr_next   = (SEEN_W'(h_eff) < seen_inc) ? AW'(h_eff) : AW'(seen_inc - 1'b1);
            init       = 1'b1;
            state_next = ST_TAP;
          end else if (SEEN_W'(h_eff) < seen_inc) begin
            ctr_next   = AW'(h_eff);
            init       = 1'b1;
            state_next = ST_TAP;
          end
        end
      end
      ST_TAP: begin
        if (issue) begin
          pv_next = 1'b1;
          pw_next = WW'(AW'(hcur) + AW'(1) - tap_dist);
          j_next  = j + 1'b1;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid || dout.ready) begin
          ovalid_next = 1'b1;
          osm_next    = res;
          olast_next  = lastf && (ctr == '0);
          if (lastf && (ctr != '0)) begin
            ctr_next   = ctr - 1'b1;
            init       = 1'b1;
            state_next = ST_TAP;
          end else begin
            if (lastf) begin
              seen_next = '0;
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // start a new tap pass at the youngest in-range age
    if (init) begin
      j_next   = (ctr_next >= AW'(hcur_next)) ? ctr_next - AW'(hcur_next) : '0;
      acc_next = '0;
      den_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      half_width <= HALF_RESET;
      seen       <= '0;
      wr_ptr     <= '0;
      pv         <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      state  <= state_next;
      seen   <= seen_next;
      pv     <= pv_next;
      ovalid <= ovalid_next;
      if (cfg.valid && cfg.ready) begin
        half_width <= cfg.data;
      end
      // advance the write pointer on each sample transfer
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hcur  <= hcur_next;
    ctr   <= ctr_next;
    j     <= j_next;
    lastf <= lastf_next;
    pw    <= pw_next;
    acc   <= acc_next;
    den   <= den_next;
    osm   <= osm_next;
    olast <= olast_next;
  end

  // a divide never starts while one is in flight
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // a tap read is only pending right after the tap pass issued it
  assert property (@(posedge clk) disable iff (rst) pv |-> $past(state == ST_TAP))
    else $error("tap pending outside tap pass");

  // the center tap is always present, so the divisor is never zero
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (den != '0))
    else $error("zero divisor at divide start");

  // the stream count is cleared once the final output of a stream is loaded
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && state_next == ST_IDLE && lastf) |=> (seen == '0))
    else $error("stream count not cleared after flush");

  // a pending tap always carries a nonzero weight
  assert property (@(posedge clk) disable iff (rst) pv |-> (pw != '0))
    else $error("zero tap weight");

endmodule

// File: test/tsf_smoothing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsf_smoothing_checker - result predictor and comparator for the tent filter
// Watches the sample, result and half-width channels. Keeps its own sample
// window, stream count and register copy, and works out the smoothed values
// that every accepted sample produces. Each result transfer is compared with
// the oldest value still owed.
// ----------------------------------------------------------------------------
module tsf_smoothing_checker import tsf_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic clk,
  input  logic rst,
  tsf_in_if    din,
  tsf_out_if   dout,
  tsf_cfg_if   cfg,
  output int   fail_count,
  output int   results_owed
);

  localparam int WIN_DEPTH = 2 * MAX_HALF + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_res;
  } smooth_out_t;

  logic signed [SAMPLE_W-1:0] win [WIN_DEPTH];
  logic [SEEN_W-1:0]          seen;
  logic [HALF_W-1:0]          half_reg;
  smooth_out_t                smoothed_q [$];
  int                         err_cnt = 0;
  int                         owed_cnt = 0;

  assign fail_count   = err_cnt;
  assign results_owed = owed_cnt;

  // Tent-weighted mean centred at window age ctr; absent taps drop out of
  // both the sum and the divisor. Round half away from zero, then clamp.
  function automatic logic [SAMPLE_W-1:0] smooth_at(input int ctr, input int h);
    longint acc, den, w, mag, q, r;
    bit     neg;
    acc = 0;
    den = 0;
    for (int d = 0; d <= h; d++) begin
      w = h + 1 - d;
      if (ctr >= d) begin
        acc += w * win[ctr-d];
        den += w;
      end
      if (d > 0 && ctr + d < int'(seen) && ctr + d < WIN_DEPTH) begin
        acc += w * win[ctr+d];
        den += w;
      end
    end
    if (den <= 0) den = 1;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    q   = (2 * mag + den) / (2 * den);
    r   = neg ? -q : q;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  // Shift one sample in and queue every result it produces.
  function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s,
                                      input logic is_last);
    int h;
    h = (int'(half_reg) > MAX_HALF) ? MAX_HALF : int'(half_reg);
    for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = s;
    if (seen < SEEN_MAX) seen = seen + 1'b1;
    if (!is_last) begin
      if (h < int'(seen)) smoothed_q.push_back('{smoothed: smooth_at(h, h), last_res: 1'b0});
    end else begin
      // flush: centres from age h down to the newest sample
      for (int a = h; a >= 0; a--) begin
        if (a < int'(seen))
          smoothed_q.push_back('{smoothed: smooth_at(a, h), last_res: (a == 0)});
      end
      seen = '0;
    end
  endfunction

  always @(posedge clk) begin
    smooth_out_t want;
    if (rst) begin
      half_reg = HALF_RESET;
      seen     = '0;
      smoothed_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) half_reg = cfg.data;
      if (dout.valid && dout.ready) begin
        if (smoothed_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual smoothed %0d last_res %0b",
                   $time, $signed(dout.smoothed), dout.last_res);
        end else begin
          want = smoothed_q.pop_front();
          if (dout.smoothed !== want.smoothed) begin
            err_cnt++;
            $display("%0t: smoothed mismatch, expected %0d, actual %0d", $time,
                     $signed(want.smoothed), $signed(dout.smoothed));
          end
          if (dout.last_res !== want.last_res) begin
            err_cnt++;
            $display("%0t: last_res mismatch, expected %0b, actual %0b", $time,
                     want.last_res, dout.last_res);
          end
        end
      end
      if (din.valid && din.ready) take_sample(din.sample, din.last);
    end
    owed_cnt <= smoothed_q.size();
  end

endmodule

// File: test/triangular_smoothing_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangular_smoothing_filter_unit_tb - stimulus and verdict for the filter
// Drives sample streams under a range of half widths, first a directed set
// (extremes, rounding ties, short streams, saturated width, a width change
// inside a stream), then random streams. The checker beside the block
// predicts and compares every result; this module stimulates and reports.
// ----------------------------------------------------------------------------
module triangular_smoothing_filter_unit_tb;
  import tsf_pkg::*;

  localparam int MAX_HALF     = MAX_HALF_DEF;
  // total random-phase samples, then the tail that runs without idling
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_TAIL    = 40;
  // settle wait derived from one full output at the widest kernel
  localparam int SETTLE_CYCLES = 2 * ((2 * MAX_HALF + 1) + 27 + 4) + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   stall_left = 0;
  int   samples_sent = 0;
  int   fail_count;
  int   results_owed;

  tsf_in_if  din ();
  tsf_out_if dout ();
  tsf_cfg_if cfg ();

  triangular_smoothing_filter_unit #(.MAX_HALF(MAX_HALF)) u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  tsf_smoothing_checker #(.MAX_HALF(MAX_HALF)) u_check (
    .clk          (clk),
    .rst          (rst),
    .din          (din),
    .dout         (dout),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #5 clk = ~clk;

  // Result side: stall in random bursts; hold ready high
  // once the run enters its calm tail.
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      dout.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      dout.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      dout.ready <= 1'b1;
    end
  end

  // Offer one sample and hold it until the transfer. An optional idle burst
  // comes first; consecutive samples keep valid high without a dip.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid  <= 1'b1;
    din.sample <= s;
    din.last   <= is_last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid, wait until every owed result has arrived, then let the
  // block finish any tap pass that produces nothing before touching cfg.
  task automatic settle_idle();
    din.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the half-width register; the block must be idle here.
  task automatic write_half(input logic [HALF_W-1:0] v);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // One stream of len random samples, the final one marked last. Mix full
  // range values with the two extremes and small values near zero, which
  // make rounding ties common.
  task automatic send_stream(input int len);
    logic signed [SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       s = SAT_POS;
        1:       s = SAT_NEG;
        2, 3:    s = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
        default: s = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  initial begin
    int rand_start;
    int half_pick;
    int half_eff;
    int stream_len;
    int phase;

    din.valid  = 1'b0;
    din.sample = '0;
    din.last   = 1'b0;
    cfg.valid  = 1'b0;
    cfg.data   = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset width of one: a single-sample stream, extremes, and tie cases
    // (1,0,1 lands on +0.5, -1,0,-1 on -0.5).
    send_sample(SAT_NEG, 1'b1);
    send_sample(SAT_POS, 1'b0);
    send_sample(SAT_POS, 1'b0);
    send_sample(SAT_NEG, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);
    settle_idle();

    // Zero width: every sample passes straight through.
    write_half(5'd0);
    send_sample(SAT_NEG, 1'b0);
    send_sample(SAT_POS, 1'b0);
    send_sample(16'sd5, 1'b1);
    settle_idle();

    // Widest register value saturates to the kernel limit; stream far
    // shorter than the kernel.
    write_half(5'd31);
    send_sample(SAT_POS, 1'b0);
    send_sample(SAT_NEG, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(SAT_POS, 1'b1);
    settle_idle();

    // Width change inside a stream: the new width applies from the next
    // sample onward.
    write_half(5'd2);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd11, 1'b0);
    settle_idle();
    write_half(5'd4);
    send_sample(16'sd13, 1'b0);
    send_sample(-16'sd3, 1'b1);
    settle_idle();

    // Random phases: pick a width, send one to three streams, drain.
    rand_start = samples_sent;
    phase = 0;
    while (samples_sent - rand_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: half_pick = $urandom_range(0, 4);
        6, 7:             half_pick = $urandom_range(5, 15);
        8:                half_pick = MAX_HALF;
        default:          half_pick = $urandom_range(MAX_HALF + 1, 31);
      endcase
      // open with the kernel limit so the widest tent is always covered
      if (phase == 0) half_pick = MAX_HALF;
      half_eff = (half_pick > MAX_HALF) ? MAX_HALF : half_pick;
      write_half(half_pick[HALF_W-1:0]);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 11) == 0)
          stream_len = $urandom_range(34, 70);   // longer than the window; may run the stream count to saturation
        else
          stream_len = $urandom_range(1, 2 * half_eff + 4);
        if (RANDOM_ITEMS - (samples_sent - rand_start) < CALM_TAIL) calm = 1'b1;
        send_stream(stream_len);
      end
      settle_idle();
      phase++;
    end

    calm = 1'b1;
    settle_idle();

    if (fail_count == 0) begin
      $display("triangular_smoothing_filter_unit verification clean");
    end else begin
      $display("triangular_smoothing_filter_unit verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #30_000_000;
    $display("triangular_smoothing_filter_unit verification failed");
    $finish;
  end

endmodule
